// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on a clock, disabled in reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication on a clock, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- src/mau_pkg.sv -----
`default_nettype none

package mau_pkg;

   localparam int WORD_BITS = 32;
   localparam int LONG_BITS = 64;

   typedef struct packed {
      logic                 kind;
      logic                 signed_mode;
      logic                 accumulate;
      logic                 set_flags;
      logic [WORD_BITS-1:0] multiplicand;
      logic [WORD_BITS-1:0] multiplier;
      logic [WORD_BITS-1:0] addend_low;
      logic [WORD_BITS-1:0] addend_high;
   } mau_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] result_low;
      logic [WORD_BITS-1:0] result_high;
      logic                 flag_negative;
      logic                 flag_zero;
      logic                 flags_written;
   } mau_rsp_type;

   // Control carried alongside the datapath.
   typedef struct packed {
      logic kind;
      logic set_flags;
   } mau_ctl_type;

   localparam logic KIND_SHORT = 1'b0;
   localparam logic KIND_LONG  = 1'b1;

endpackage

`default_nettype wire

// ----- src/mau_mul_stage.sv -----
`default_nettype none

module mau_mul_stage
   import mau_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 valid_i,
   input  wire mau_req_type          req_i,
   output logic                      valid_o,
   output mau_ctl_type               ctl_o,
   output logic [LONG_BITS-1:0]      product_o,
   output logic [LONG_BITS-1:0]      addend_o
);

   logic                        valid_ff;
   mau_ctl_type                 ctl_ff;
   logic [LONG_BITS-1:0]        product_ff;
   logic [LONG_BITS-1:0]        addend_ff;

   logic                        sign_ext;
   logic signed [WORD_BITS:0]   op_a;
   logic signed [WORD_BITS:0]   op_b;
   logic signed [2*WORD_BITS+1:0] full_product;
   logic [LONG_BITS-1:0]        product_in;
   logic [LONG_BITS-1:0]        addend_in;
   mau_ctl_type                 ctl_in;

   // 33x33 signed multiply covers both signed and unsigned operands.
   always_comb begin
      sign_ext     = (req_i.kind == KIND_LONG) && req_i.signed_mode;
      op_a         = {sign_ext & req_i.multiplicand[WORD_BITS-1], req_i.multiplicand};
      op_b         = {sign_ext & req_i.multiplier[WORD_BITS-1], req_i.multiplier};
      full_product = op_a * op_b;
      product_in   = full_product[LONG_BITS-1:0];
      if (!req_i.accumulate) begin
         addend_in = '0;
      end else if (req_i.kind == KIND_LONG) begin
         addend_in = {req_i.addend_high, req_i.addend_low};
      end else begin
         addend_in = {{WORD_BITS{1'b0}}, req_i.addend_low};
      end
      ctl_in.kind      = req_i.kind;
      ctl_in.set_flags = req_i.set_flags;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff     <= ctl_in;
      product_ff <= product_in;
      addend_ff  <= addend_in;
   end

   assign valid_o   = valid_ff;
   assign ctl_o     = ctl_ff;
   assign product_o = product_ff;
   assign addend_o  = addend_ff;

endmodule

`default_nettype wire

// ----- src/mau_add_stage.sv -----
`default_nettype none

module mau_add_stage
   import mau_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 valid_i,
   input  wire mau_ctl_type          ctl_i,
   input  wire logic [LONG_BITS-1:0] product_i,
   input  wire logic [LONG_BITS-1:0] addend_i,
   output logic                      valid_o,
   output mau_ctl_type               ctl_o,
   output logic [LONG_BITS-1:0]      sum_o
);

   logic                 valid_ff;
   mau_ctl_type          ctl_ff;
   logic [LONG_BITS-1:0] sum_ff;
   logic [LONG_BITS-1:0] sum_in;

   // Wraps modulo 2^64; short form only uses the low word.
   assign sum_in = product_i + addend_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff <= ctl_i;
      sum_ff <= sum_in;
   end

   assign valid_o = valid_ff;
   assign ctl_o   = ctl_ff;
   assign sum_o   = sum_ff;

endmodule

`default_nettype wire

// ----- src/mau_out_stage.sv -----
`default_nettype none

module mau_out_stage
   import mau_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 valid_i,
   input  wire mau_ctl_type          ctl_i,
   input  wire logic [LONG_BITS-1:0] sum_i,
   output logic                      valid_o,
   output mau_rsp_type               rsp_o
);

   logic        valid_ff;
   mau_rsp_type rsp_ff;
   mau_rsp_type rsp_in;
   logic        neg;
   logic        zero;

   always_comb begin
      rsp_in.result_low = sum_i[WORD_BITS-1:0];
      if (ctl_i.kind == KIND_LONG) begin
         rsp_in.result_high = sum_i[LONG_BITS-1:WORD_BITS];
         neg                = sum_i[LONG_BITS-1];
         zero               = (sum_i == '0);
      end else begin
         rsp_in.result_high = '0;
         neg                = sum_i[WORD_BITS-1];
         zero               = (sum_i[WORD_BITS-1:0] == '0);
      end
      rsp_in.flag_negative = ctl_i.set_flags & neg;
      rsp_in.flag_zero     = ctl_i.set_flags & zero;
      rsp_in.flags_written = ctl_i.set_flags;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign valid_o = valid_ff;
   assign rsp_o   = rsp_ff;

endmodule

`default_nettype wire

// ----- src/multiply_accumulate_unit.sv -----
// Multiply-accumulate execution unit: 32-bit multiply, multiply-accumulate,
// and 64-bit signed/unsigned long multiply with optional 64-bit accumulate.
// Input channel: drive req_data and raise start; the transfer happens at a
// rising edge with start high and busy low. busy is low at all times except
// in reset and the cycle after it, so a new request may be issued every cycle.
// Result channel: rsp_data is valid for exactly one cycle, marked by
// rsp_strobe. The receiver cannot hold results off, so none is needed.
// Path from the transfer to rsp_strobe: multiply stage, 64-bit add stage,
// flag/format stage, each registered. Throughput: one item per cycle.
// The 33x33 multiplier in the first stage sets the critical path.
// Reset (synchronous, active high) clears all stage valid bits; items in
// flight are dropped and no strobe follows them.
`default_nettype none

`include "assert_macros.svh"

module multiply_accumulate_unit
   import mau_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire mau_req_type req_data,
   output logic             rsp_strobe,
   output mau_rsp_type      rsp_data
);

   logic                 busy_ff;
   logic                 accept;
   logic                 mul_valid;
   mau_ctl_type          mul_ctl;
   logic [LONG_BITS-1:0] mul_product;
   logic [LONG_BITS-1:0] mul_addend;
   logic                 add_valid;
   mau_ctl_type          add_ctl;
   logic [LONG_BITS-1:0] add_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   mau_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .valid_i   (accept),
      .req_i     (req_data),
      .valid_o   (mul_valid),
      .ctl_o     (mul_ctl),
      .product_o (mul_product),
      .addend_o  (mul_addend)
   );

   mau_add_stage u_add (
      .clock     (clock),
      .reset     (reset),
      .valid_i   (mul_valid),
      .ctl_i     (mul_ctl),
      .product_i (mul_product),
      .addend_i  (mul_addend),
      .valid_o   (add_valid),
      .ctl_o     (add_ctl),
      .sum_o     (add_sum)
   );

   mau_out_stage u_out (
      .clock   (clock),
      .reset   (reset),
      .valid_i (add_valid),
      .ctl_i   (add_ctl),
      .sum_i   (add_sum),
      .valid_o (rsp_strobe),
      .rsp_o   (rsp_data)
   );

   `ASSERT_IMPLY(a_latency, clock, reset, accept, ##3 rsp_strobe, "strobe missing 3 cycles after transfer")
   `ASSERT_IMPLY(a_no_spurious, clock, reset, rsp_strobe, $past(accept, 3), "strobe without a transfer")
   `ASSERT_IMPLY(a_short_high, clock, reset, rsp_strobe && ($past(req_data.kind, 3) == KIND_SHORT), rsp_data.result_high == '0, "short form high word not zero")
   `ASSERT_AT(a_flags_off, clock, reset, !rsp_strobe || rsp_data.flags_written || (!rsp_data.flag_negative && !rsp_data.flag_zero), "flags set without flag update")

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import mau_pkg::*;

   localparam int TOTAL_RANDOM = 1800;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      mau_req_type req;
      bit          drain_first;
   } pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   mau_req_type req_data = '0;
   logic        busy;
   logic        rsp_strobe;
   mau_rsp_type rsp_data;

   pending_type pending_items[$];
   mau_rsp_type expected_results[$];
   int          failures = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          gap_left = 0;

   multiply_accumulate_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   function automatic mau_rsp_type predict_mac(mau_req_type r);
      logic [LONG_BITS-1:0] a_ext;
      logic [LONG_BITS-1:0] b_ext;
      logic [LONG_BITS-1:0] long_sum;
      logic [WORD_BITS-1:0] short_sum;
      logic                 negative;
      logic                 is_zero;
      mau_rsp_type          o;
      if (r.kind == KIND_LONG) begin
         if (r.signed_mode) begin
            a_ext = {{WORD_BITS{r.multiplicand[WORD_BITS-1]}}, r.multiplicand};
            b_ext = {{WORD_BITS{r.multiplier[WORD_BITS-1]}}, r.multiplier};
         end else begin
            a_ext = {{WORD_BITS{1'b0}}, r.multiplicand};
            b_ext = {{WORD_BITS{1'b0}}, r.multiplier};
         end
         long_sum = a_ext * b_ext;
         if (r.accumulate) begin
            long_sum = long_sum + {r.addend_high, r.addend_low};
         end
         o.result_low  = long_sum[WORD_BITS-1:0];
         o.result_high = long_sum[LONG_BITS-1:WORD_BITS];
         negative      = long_sum[LONG_BITS-1];
         is_zero       = (long_sum == '0);
      end else begin
         short_sum = r.multiplicand * r.multiplier;
         if (r.accumulate) begin
            short_sum = short_sum + r.addend_low;
         end
         o.result_low  = short_sum;
         o.result_high = '0;
         negative      = short_sum[WORD_BITS-1];
         is_zero       = (short_sum == '0);
      end
      o.flag_negative = r.set_flags & negative;
      o.flag_zero     = r.set_flags & is_zero;
      o.flags_written = r.set_flags;
      return o;
   endfunction

   function automatic mau_req_type make_item(logic kind, logic sgn, logic acc, logic flg,
                                             logic [31:0] a, logic [31:0] b,
                                             logic [31:0] lo, logic [31:0] hi);
      mau_req_type r;
      r.kind         = kind;
      r.signed_mode  = sgn;
      r.accumulate   = acc;
      r.set_flags    = flg;
      r.multiplicand = a;
      r.multiplier   = b;
      r.addend_low   = lo;
      r.addend_high  = hi;
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'h0000_0001;
         5: return $urandom_range(0, 15);
         6: return -$urandom_range(1, 16);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_item(mau_req_type r, bit drain);
      pending_type p;
      p.req         = r;
      p.drain_first = drain;
      pending_items.push_back(p);
   endtask

   task automatic compare_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         if (failures < REPORT_LIMIT) begin
            $display("mismatch at cycle %0d on %s: expected %h, got %h",
                     cycle_count, field, want, got);
         end
         failures++;
      end
   endtask

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multiply_accumulate_unit regression: fail");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      bit next_start;
      bit holding;
      next_start = 1'b0;
      holding    = 1'b0;
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(predict_mac(req_data));
            void'(pending_items.pop_front());
         end else begin
            holding = start;
         end
         if (holding) begin
            next_start = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_items.size() > 0 &&
                      !(pending_items[0].drain_first && expected_results.size() > 0)) begin
            next_start = 1'b1;
            req_data <= pending_items[0].req;
            if (burst_left <= 1) begin
               gap_left   = $urandom_range(0, 6);
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                        : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end
         start <= next_start;
      end
   end

   // monitor
   always @(posedge clock) begin
      mau_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            if (failures < REPORT_LIMIT) begin
               $display("unexpected transfer at cycle %0d: %p", cycle_count, rsp_data);
            end
            failures++;
         end else begin
            want = expected_results.pop_front();
            compare_field("result_low", rsp_data.result_low, want.result_low);
            compare_field("result_high", rsp_data.result_high, want.result_high);
            compare_field("flag_negative", 32'(rsp_data.flag_negative),
                          32'(want.flag_negative));
            compare_field("flag_zero", 32'(rsp_data.flag_zero), 32'(want.flag_zero));
            compare_field("flags_written", 32'(rsp_data.flags_written),
                          32'(want.flags_written));
         end
      end
   end

   initial begin
      mau_req_type r;
      // 32-bit form
      queue_item(make_item(KIND_SHORT, 1'b0, 1'b0, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0), 1'b0);
      queue_item(make_item(KIND_SHORT, 1'b0, 1'b0, 1'b1, '1, '1, '1, '1), 1'b0);
      queue_item(make_item(KIND_SHORT, 1'b0, 1'b1, 1'b1, '1, 32'h1, 32'h1, 32'h0), 1'b0);
      queue_item(make_item(KIND_SHORT, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 32'h1,
                           32'h0, 32'h0), 1'b0);
      queue_item(make_item(KIND_SHORT, 1'b1, 1'b1, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0,
                           32'h0F0F_0F0F, '1), 1'b0);
      queue_item(make_item(KIND_SHORT, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h3, '1, '1), 1'b0);
      queue_item(make_item(KIND_SHORT, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h2, '1,
                           32'h5555_5555), 1'b0);
      // long form
      queue_item(make_item(KIND_LONG, 1'b0, 1'b0, 1'b1, '1, '1, 32'h0, 32'h0), 1'b0);
      queue_item(make_item(KIND_LONG, 1'b1, 1'b0, 1'b1, '1, '1, 32'h0, 32'h0), 1'b0);
      queue_item(make_item(KIND_LONG, 1'b1, 1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000,
                           32'h0, 32'h0), 1'b0);
      queue_item(make_item(KIND_LONG, 1'b1, 1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'h0, 32'h0), 1'b0);
      queue_item(make_item(KIND_LONG, 1'b0, 1'b1, 1'b1, '1, '1, '1, '1), 1'b0);
      queue_item(make_item(KIND_LONG, 1'b1, 1'b1, 1'b1, '1, 32'h1, 32'h1, 32'h0), 1'b0);
      queue_item(make_item(KIND_LONG, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 32'h2, '1, '1), 1'b0);
      queue_item(make_item(KIND_LONG, 1'b1, 1'b0, 1'b0, 32'h8000_0000, 32'h1,
                           32'h0, 32'h0), 1'b0);
      queue_item(make_item(KIND_LONG, 1'b0, 1'b0, 1'b1, 32'h0, '1, 32'h0, 32'h0), 1'b0);
      queue_item(make_item(KIND_LONG, 1'b0, 1'b1, 1'b1, 32'h0, 32'h0, 32'h0,
                           32'h8000_0000), 1'b0);
      queue_item(make_item(KIND_LONG, 1'b1, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'hDEAD_BEEF, 32'hCAFE_F00D), 1'b0);
      for (int i = 0; i < TOTAL_RANDOM; i++) begin
         r.kind         = 1'($urandom_range(0, 1));
         r.signed_mode  = 1'($urandom_range(0, 1));
         r.accumulate   = 1'($urandom_range(0, 1));
         r.set_flags    = 1'($urandom_range(0, 1));
         r.multiplicand = pick_word();
         r.multiplier   = pick_word();
         r.addend_low   = pick_word();
         r.addend_high  = pick_word();
         queue_item(r, (i == 0) || (i == TOTAL_RANDOM / 2) || ($urandom_range(0, 299) == 0));
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() != 0 || expected_results.size() != 0 || start) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         failures++;
      end
      if (failures == 0) begin
         $display("multiply_accumulate_unit regression: pass");
      end else begin
         $display("multiply_accumulate_unit regression: fail");
      end
      $finish;
   end

endmodule
